/* src/cfsu_pkg.sv */
package cfsu_pkg;

	localparam int unsigned STACK_DEPTH = 256;
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 64;

	localparam logic [7:0]  STATUS_PULL_MASK = 8'hEF;
	localparam logic [7:0]  STATUS_PULL_SET  = 8'h20;
	localparam logic [7:0]  STATUS_PUSH_SET  = 8'h30;
	localparam logic [15:0] PAGE_MASK        = 16'hFF00;
	localparam logic [15:0] OFFSET_MASK      = 16'h00FF;

	localparam int unsigned FLAG_C = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_V = 6;
	localparam int unsigned FLAG_N = 7;

	typedef enum logic [3:0] {
		FN_JMP_ABS = 4'd0,
		FN_JMP_IND = 4'd1,
		FN_BRANCH  = 4'd2,
		FN_BRK     = 4'd3,
		FN_JSR     = 4'd4,
		FN_RTS     = 4'd5,
		FN_RTI     = 4'd6,
		FN_PHA     = 4'd7,
		FN_PLA     = 4'd8,
		FN_PHP     = 4'd9,
		FN_PLP     = 4'd10
	} func_t;

	typedef enum logic [1:0] {
		CT_ZERO     = 2'd0,
		CT_CARRY    = 2'd1,
		CT_NEGATIVE = 2'd2,
		CT_OVERFLOW = 2'd3
	} cond_flag_t;

	typedef struct packed {
		logic [7:0]        accum_in;
		logic [7:0]        status_in;
		logic [7:0]        pointer_high_byte;
		logic [7:0]        pointer_low_byte;
		logic [1:0]        instr_size;
		logic [2:0]        condition;
		logic signed [7:0] branch_offset;
		logic [15:0]       jump_target;
		logic [3:0]        func;
	} item_t;

	typedef struct packed {
		logic        break_raised;
		logic [1:0]  extra_cycles;
		logic [15:0] pointer_high_addr;
		logic [7:0]  accum_out;
		logic [7:0]  status_out;
		logic [7:0]  sp_out;
		logic [15:0] pc_out;
	} result_t;

	// Two write ports into the stack page; a call pushes two bytes at once.
	typedef struct packed {
		logic       we0;
		logic [7:0] addr0;
		logic [7:0] data0;
		logic       we1;
		logic [7:0] addr1;
		logic [7:0] data1;
	} stack_wr_t;

	typedef struct packed {
		logic [7:0] rd0;
		logic [7:0] rd1;
		logic [7:0] rd2;
	} stack_rd_t;

endpackage

/* src/cfsu_stack.sv */
module cfsu_stack
	import cfsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rd_addr0,
	input  logic [7:0] rd_addr1,
	input  stack_wr_t  wr,
	output logic [7:0] rd_data0,
	output logic [7:0] rd_data1,
	output logic       clearing
);

	logic [7:0] page_q [STACK_DEPTH];
	logic [7:0] rd_data0_q;
	logic [7:0] rd_data1_q;
	logic       clearing_q;
	logic [7:0] clear_addr_q;

	// After reset the page is zeroed one byte per cycle before any item runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q   <= 1'b1;
			clear_addr_q <= 8'd0;
		end else if (clearing_q) begin
			clear_addr_q <= clear_addr_q + 8'd1;
			if (clear_addr_q == 8'hFF) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			page_q[clear_addr_q] <= 8'd0;
		end else begin
			if (wr.we0) begin
				page_q[wr.addr0] <= wr.data0;
			end
			if (wr.we1) begin
				page_q[wr.addr1] <= wr.data1;
			end
		end
		rd_data0_q <= page_q[rd_addr0];
		rd_data1_q <= page_q[rd_addr1];
	end

	assign rd_data0 = rd_data0_q;
	assign rd_data1 = rd_data1_q;
	assign clearing = clearing_q;

endmodule

/* src/cfsu_exec.sv */
module cfsu_exec
	import cfsu_pkg::*;
(
	input  item_t       item,
	input  logic [15:0] pc,
	input  logic [7:0]  sp,
	input  stack_rd_t   rd,
	output result_t     res,
	output logic [15:0] pc_next,
	output logic [7:0]  sp_next,
	output stack_wr_t   wr
);

	logic        taken;
	logic        flag_bit;
	logic [15:0] branch_pc;
	logic [15:0] ret_addr;
	logic [15:0] size_ext;
	logic [7:0]  pla_status;

	assign size_ext  = {14'd0, item.instr_size};
	assign branch_pc = pc + {{8{item.branch_offset[7]}}, item.branch_offset};
	assign ret_addr  = pc + size_ext - 16'd1;

	always_comb begin
		unique case (cond_flag_t'(item.condition[2:1]))
			CT_ZERO:     flag_bit = item.status_in[FLAG_Z];
			CT_CARRY:    flag_bit = item.status_in[FLAG_C];
			CT_NEGATIVE: flag_bit = item.status_in[FLAG_N];
			CT_OVERFLOW: flag_bit = item.status_in[FLAG_V];
			default:     flag_bit = 1'b0;
		endcase
		// Odd condition codes branch on a clear flag.
		taken = item.condition[0] ? !flag_bit : flag_bit;
	end

	always_comb begin
		pla_status         = item.status_in;
		pla_status[FLAG_Z] = (rd.rd0 == 8'd0);
		pla_status[FLAG_N] = rd.rd0[7];
	end

	always_comb begin
		pc_next = pc;
		sp_next = sp;
		wr      = '0;
		res     = '0;
		res.status_out = item.status_in;
		res.accum_out  = item.accum_in;
		unique case (func_t'(item.func))
			FN_JMP_ABS: begin
				pc_next = item.jump_target;
			end
			FN_JMP_IND: begin
				res.pointer_high_addr = (item.jump_target & PAGE_MASK)
					| ((item.jump_target + 16'd1) & OFFSET_MASK);
				pc_next = {item.pointer_high_byte, item.pointer_low_byte};
			end
			FN_BRANCH: begin
				if (taken) begin
					pc_next = branch_pc;
					res.extra_cycles = (branch_pc[15:8] != pc[15:8]) ? 2'd2 : 2'd1;
				end
			end
			FN_BRK: begin
				pc_next = pc + size_ext;
				res.break_raised = 1'b1;
			end
			FN_JSR: begin
				wr.we0   = 1'b1;
				wr.addr0 = sp;
				wr.data0 = ret_addr[15:8];
				wr.we1   = 1'b1;
				wr.addr1 = sp - 8'd1;
				wr.data1 = ret_addr[7:0];
				sp_next  = sp - 8'd2;
				pc_next  = item.jump_target;
			end
			FN_RTS: begin
				sp_next = sp + 8'd2;
				pc_next = {rd.rd1, rd.rd0} + 16'd1;
			end
			FN_RTI: begin
				sp_next = sp + 8'd3;
				res.status_out = (rd.rd0 & STATUS_PULL_MASK) | STATUS_PULL_SET;
				pc_next = {rd.rd2, rd.rd1};
			end
			FN_PHA: begin
				wr.we0   = 1'b1;
				wr.addr0 = sp;
				wr.data0 = item.accum_in;
				sp_next  = sp - 8'd1;
			end
			FN_PLA: begin
				sp_next        = sp + 8'd1;
				res.accum_out  = rd.rd0;
				res.status_out = pla_status;
			end
			FN_PHP: begin
				wr.we0   = 1'b1;
				wr.addr0 = sp;
				wr.data0 = item.status_in | STATUS_PUSH_SET;
				sp_next  = sp - 8'd1;
			end
			FN_PLP: begin
				sp_next = sp + 8'd1;
				res.status_out = (rd.rd0 & STATUS_PULL_MASK) | STATUS_PULL_SET;
			end
			default: begin
			end
		endcase
		res.pc_out = pc_next;
		res.sp_out = sp_next;
	end

endmodule

/* src/cpu_control_flow_stack_unit.sv */
// Control-flow and stack unit: runs one jump, branch, break, call, return,
// interrupt return, push or pull instruction per item.
// Input channel s_axis: one instruction item with its operands, the fetched
// indirect pointer bytes and the current status and accumulator.
// Output channel m_axis: one result item per instruction with the new program
// counter, stack pointer, status, accumulator, indirect high-byte address,
// extra branch cycles and the break flag.
// An accepted item sits in the input register and executes against the held
// counter, stack pointer and stack page into the result register. Pull
// accumulator, pull status and return first wait there for a stack read, and
// interrupt return for a second read of the high byte, since the stack page
// is a memory with two registered read ports. Other instructions go at one
// item per cycle while the receiver does not stall; a pulling instruction
// holds the input register until its reads are done.
// When the receiver stalls, the result register holds its item and one more
// item may still wait in the input register; after that s_axis_tready drops.
// Reset clears the program counter and the stack pointer and empties both
// registers; the stack page is then zeroed byte by byte in a clearing pass,
// during which at most one item is taken in and none executes.
module cpu_control_flow_stack_unit
	import cfsu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// func, jump_target, branch_offset, condition, instr_size,
	// pointer_low_byte, pointer_high_byte, status_in, accum_in (from bit 0)
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// pc_out, sp_out, status_out, accum_out, pointer_high_addr,
	// extra_cycles, break_raised (from bit 0)
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic        valid_s1;
	item_t       item_s1;
	logic        out_valid_q;
	result_t     res_q;
	logic [15:0] pc_q;
	logic [7:0]  sp_q;
	logic [1:0]  phase_q;
	logic [7:0]  pull0_q;
	logic [7:0]  pull1_q;

	logic        commit;
	logic        exec_ready;
	logic        clearing;
	logic        is_rti;
	logic [1:0]  phase_last;
	logic [7:0]  rd_addr0;
	logic [7:0]  rd_addr1;
	logic [7:0]  rd_data0;
	logic [7:0]  rd_data1;
	result_t     res;
	logic [15:0] pc_next;
	logic [7:0]  sp_next;
	stack_wr_t   wr;
	stack_wr_t   wr_gated;
	stack_rd_t   pulled;

	assign is_rti = (item_s1.func == FN_RTI);

	// Number of read cycles an instruction needs before it can execute.
	always_comb begin
		unique case (func_t'(item_s1.func))
			FN_RTS, FN_PLA, FN_PLP: phase_last = 2'd1;
			FN_RTI:                 phase_last = 2'd2;
			default:                phase_last = 2'd0;
		endcase
	end

	assign exec_ready    = valid_s1 && !clearing && (phase_q == phase_last);
	assign commit        = exec_ready && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || commit;

	// Interrupt return reads the status and low byte first, then the high byte.
	assign rd_addr0 = (is_rti && phase_q != 2'd0) ? sp_q + 8'd3 : sp_q + 8'd1;
	assign rd_addr1 = sp_q + 8'd2;

	always_comb begin
		if (is_rti) begin
			pulled.rd0 = pull0_q;
			pulled.rd1 = pull1_q;
			pulled.rd2 = rd_data0;
		end else begin
			pulled.rd0 = rd_data0;
			pulled.rd1 = rd_data1;
			pulled.rd2 = 8'd0;
		end
	end

	always_comb begin
		wr_gated     = wr;
		wr_gated.we0 = wr.we0 && commit;
		wr_gated.we1 = wr.we1 && commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (commit) begin
			phase_q <= 2'd0;
		end else if (valid_s1 && !clearing && phase_q != phase_last) begin
			phase_q <= phase_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == 2'd1) begin
			pull0_q <= rd_data0;
			pull1_q <= rd_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pc_q        <= 16'd0;
			sp_q        <= 8'd0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				pc_q        <= pc_next;
				sp_q        <= sp_next;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	cfsu_exec u_exec (
		.item    (item_s1),
		.pc      (pc_q),
		.sp      (sp_q),
		.rd      (pulled),
		.res     (res),
		.pc_next (pc_next),
		.sp_next (sp_next),
		.wr      (wr)
	);

	cfsu_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.wr       (wr_gated),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1),
		.clearing (clearing)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_q};

	a_sp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(sp_q))
		else $error("stack pointer moved without an executed item");

	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(pc_q))
		else $error("program counter moved without an executed item");

	a_extra_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.extra_cycles != 2'd3))
		else $error("extra cycle count out of range");

	a_brk_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.break_raised |-> (res_q.extra_cycles == 2'd0))
		else $error("break result carries branch cycles");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while both registers are full");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !commit)
		else $error("item executed while the stack page was being cleared");

endmodule
